FILE: rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
// Holds request/result payload structs, engine state, command codes and the phase line function.
// No dependencies.
package i2cm_pkg;

    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_STOP      = 3'd2;
    localparam logic [2:0] CMD_WRITE     = 3'd3;
    localparam logic [2:0] CMD_READ_ACK  = 3'd4;
    localparam logic [2:0] CMD_READ_NACK = 3'd5;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd4;
    localparam logic [3:0]  LAST_BIT          = 4'd7;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data_byte;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_error;
        logic       rejected;
    } out_t;

    typedef struct packed {
        logic        scl;
        logic        sda;
    } lines_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  phase;
        logic [3:0]  bit_idx;
        logic [15:0] tick_count;
        logic [7:0]  shift_byte;
        lines_t      lines;
        logic        ack_flag;
        logic [7:0]  read_byte;
    } state_t;

    // Line levels set on entry to a phase of the given command.
    function automatic lines_t enter_phase(input logic [2:0] command,
                                           input logic [2:0] phase,
                                           input logic [7:0] shift_byte,
                                           input lines_t     cur);
        lines_t l;
        l = cur;
        if (command == CMD_START) begin
            if (phase == 3'd0) begin
                l.scl = 1'b1;
                l.sda = 1'b1;
            end
            else if (phase == 3'd1) l.sda = 1'b0;
            else l.scl = 1'b0;
        end
        else if (command == CMD_STOP) begin
            if (phase == 3'd0) l.scl = 1'b0;
            else if (phase == 3'd1) l.sda = 1'b0;
            else if (phase == 3'd2) l.scl = 1'b1;
            else l.sda = 1'b1;
        end
        else if (command == CMD_WRITE) begin
            if (phase == 3'd0) l.sda = shift_byte[7];
            else if (phase == 3'd1) l.scl = 1'b1;
            else if (phase == 3'd2) l.sda = 1'b1;
            else l.scl = 1'b1;
        end
        else begin
            if (phase == 3'd0) l.scl = 1'b1;
            else if (phase == 3'd1 || phase == 3'd2) l.scl = 1'b0;
            else if (phase == 3'd3) l.sda = (command == CMD_READ_ACK) ? 1'b0 : 1'b1;
            else if (phase == 3'd4) l.scl = 1'b1;
            else begin
                l.scl = 1'b0;
                l.sda = 1'b1;
            end
        end
        return l;
    endfunction

endpackage

FILE: rtl/i2c_master_bit_engine.sv
// I2C master bit engine: one timing tick per request, one result per tick. A request is
// taken on any cycle in which the result register is empty or being emptied, so ticks
// flow at one per clock and each result appears in the register in the cycle after its
// request is taken. The rate is set by the combinational step logic between the engine
// state registers and the result register. phase_ticks is written through the config
// channel, which is always ready; write it only while the engine is idle.
// Depends on i2cm_pkg and i2cm_step.
module i2c_master_bit_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  i2cm_pkg::in_t    in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output i2cm_pkg::out_t   out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [15:0]      cfg_data
);

    i2cm_pkg::state_t state_reg;
    i2cm_pkg::state_t state_next;
    i2cm_pkg::out_t   res_next;
    i2cm_pkg::out_t   res_reg;
    logic             out_valid_reg;
    logic [15:0]      phase_ticks_reg;
    logic             accept;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    i2cm_step u_step (
        .cur         (state_reg),
        .req         (in_data),
        .phase_ticks (phase_ticks_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RESET;
        end
        else if (cfg_valid)
        begin
            phase_ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.command    <= i2cm_pkg::CMD_NONE;
            state_reg.phase      <= 3'd0;
            state_reg.bit_idx    <= 4'd0;
            state_reg.tick_count <= 16'd0;
            state_reg.shift_byte <= 8'd0;
            state_reg.lines.scl  <= 1'b1;
            state_reg.lines.sda  <= 1'b1;
            state_reg.ack_flag   <= 1'b0;
            state_reg.read_byte  <= 8'd0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // hold the result while stalled, refill on each taken request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: rtl/i2cm_step.sv
// Next-state logic of the I2C master bit engine for one timing tick.
// Uses i2cm_pkg for the state, request and result types and the command codes.
// Purely combinational; the top level holds the state and result registers.
module i2cm_step (
    input  i2cm_pkg::state_t cur,
    input  i2cm_pkg::in_t    req,
    input  logic [15:0]      phase_ticks,
    output i2cm_pkg::state_t nxt,
    output i2cm_pkg::out_t   res
);

    logic [15:0] limit;
    logic        is_cmd;
    logic        done;
    logic        rej;
    logic        finish;
    logic [3:0]  bit_inc;

    assign limit   = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    assign is_cmd  = (req.func >= i2cm_pkg::CMD_START) && (req.func <= i2cm_pkg::CMD_READ_NACK);
    assign bit_inc = cur.bit_idx + 4'd1;

    always_comb
    begin
        nxt    = cur;
        done   = 1'b0;
        rej    = 1'b0;
        finish = 1'b0;
        if (cur.command != i2cm_pkg::CMD_NONE)
        begin
            rej            = is_cmd;
            nxt.tick_count = cur.tick_count + 16'd1;
            if (nxt.tick_count >= limit)
            begin
                nxt.tick_count = 16'd0;
                if (cur.command == i2cm_pkg::CMD_START)
                begin
                    if (cur.phase >= 3'd2) finish = 1'b1;
                    else nxt.phase = cur.phase + 3'd1;
                end
                else if (cur.command == i2cm_pkg::CMD_STOP)
                begin
                    if (cur.phase >= 3'd3) finish = 1'b1;
                    else nxt.phase = cur.phase + 3'd1;
                end
                else if (cur.command == i2cm_pkg::CMD_WRITE)
                begin
                    if (cur.phase == 3'd0 || cur.phase == 3'd2)
                    begin
                        nxt.phase = cur.phase + 3'd1;
                    end
                    else if (cur.phase == 3'd1)
                    begin
                        // drop SCL; release SDA after the last bit
                        nxt.lines.scl = 1'b0;
                        if (cur.bit_idx == i2cm_pkg::LAST_BIT) nxt.lines.sda = 1'b1;
                        nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
                        nxt.bit_idx    = bit_inc;
                        nxt.phase      = (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ? 3'd2 : 3'd0;
                    end
                    else
                    begin
                        nxt.lines.scl = 1'b0;
                        nxt.ack_flag  = req.sda_in;
                        finish        = 1'b1;
                    end
                end
                else
                begin
                    if (cur.phase == 3'd0)
                    begin
                        nxt.shift_byte = {cur.shift_byte[6:0], req.sda_in};
                        nxt.phase      = 3'd1;
                    end
                    else if (cur.phase == 3'd1)
                    begin
                        nxt.bit_idx = bit_inc;
                        nxt.phase   = (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ? 3'd2 : 3'd0;
                    end
                    else if (cur.phase >= 3'd5)
                    begin
                        nxt.read_byte = cur.shift_byte;
                        finish        = 1'b1;
                    end
                    else
                    begin
                        nxt.phase = cur.phase + 3'd1;
                    end
                end

                if (finish)
                begin
                    nxt.command = i2cm_pkg::CMD_NONE;
                    nxt.phase   = 3'd0;
                    nxt.bit_idx = 4'd0;
                    done        = 1'b1;
                end
                else
                begin
                    nxt.lines = i2cm_pkg::enter_phase(cur.command, nxt.phase,
                                                      nxt.shift_byte, nxt.lines);
                end
            end
        end
        else if (is_cmd)
        begin
            nxt.command    = req.func;
            nxt.phase      = 3'd0;
            nxt.bit_idx    = 4'd0;
            nxt.tick_count = 16'd0;
            nxt.shift_byte = (req.func == i2cm_pkg::CMD_WRITE) ? req.data_byte : 8'd0;
            nxt.lines      = i2cm_pkg::enter_phase(req.func, 3'd0, nxt.shift_byte, cur.lines);
        end
    end

    always_comb
    begin
        res.scl       = nxt.lines.scl;
        res.sda_out   = nxt.lines.sda;
        res.busy_res  = (nxt.command != i2cm_pkg::CMD_NONE);
        res.done_res  = done;
        res.read_data = nxt.read_byte;
        res.ack_error = nxt.ack_flag;
        res.rejected  = rej;
    end

endmodule

FILE: bench/tb.sv
// Self-checking bench for the I2C master bit engine: ticks in, one line/status result out.
// A scoreboard class predicts every result from its own model of the engine and phase_ticks.
// Depends on i2cm_pkg and the i2c_master_bit_engine RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] FUNC_SPARE_A = 3'd6;
    localparam logic [2:0] FUNC_SPARE_B = 3'd7;

    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_TICKS_GOAL = 80;

    typedef struct {
        logic [2:0]  cmd;
        logic [2:0]  phase;
        logic [3:0]  bit_idx;
        logic [15:0] ticks;
        logic [7:0]  shreg;
        logic        scl;
        logic        sda;
        logic        ack;
        logic [7:0]  rd_byte;
    } bus_state_t;

    class tick_scoreboard;
        bus_state_t       st;
        logic [15:0]      cfg_ticks;
        i2cm_pkg::out_t   expected_q[$];
        int               errors;
        int               results_seen;

        function new();
            st.cmd     = i2cm_pkg::CMD_NONE;
            st.phase   = '0;
            st.bit_idx = '0;
            st.ticks   = '0;
            st.shreg   = '0;
            st.scl     = 1'b1;
            st.sda     = 1'b1;
            st.ack     = 1'b0;
            st.rd_byte = '0;
            cfg_ticks  = i2cm_pkg::PHASE_TICKS_RESET;
            errors     = 0;
            results_seen = 0;
        endfunction

        // Set the line levels on entry to the current phase.
        function void drive_lines(inout bus_state_t s);
            case (s.cmd)
                i2cm_pkg::CMD_START:
                    case (s.phase)
                        3'd0:
                        begin
                            s.scl = 1'b1;
                            s.sda = 1'b1;
                        end
                        3'd1: s.sda = 1'b0;
                        default: s.scl = 1'b0;
                    endcase
                i2cm_pkg::CMD_STOP:
                    case (s.phase)
                        3'd0: s.scl = 1'b0;
                        3'd1: s.sda = 1'b0;
                        3'd2: s.scl = 1'b1;
                        default: s.sda = 1'b1;
                    endcase
                i2cm_pkg::CMD_WRITE:
                    case (s.phase)
                        3'd0: s.sda = s.shreg[7];
                        3'd1: s.scl = 1'b1;
                        3'd2: s.sda = 1'b1;
                        default: s.scl = 1'b1;
                    endcase
                default:
                    case (s.phase)
                        3'd0: s.scl = 1'b1;
                        3'd1, 3'd2: s.scl = 1'b0;
                        3'd3: s.sda = (s.cmd == i2cm_pkg::CMD_READ_ACK) ? 1'b0 : 1'b1;
                        3'd4: s.scl = 1'b1;
                        default:
                        begin
                            s.scl = 1'b0;
                            s.sda = 1'b1;
                        end
                    endcase
            endcase
        endfunction

        // Close the current phase; returns 1 when the command is complete.
        function bit close_phase(inout bus_state_t s, input logic sda_in);
            case (s.cmd)
                i2cm_pkg::CMD_START:
                begin
                    if (s.phase >= 3'd2) return 1'b1;
                    s.phase = s.phase + 3'd1;
                end
                i2cm_pkg::CMD_STOP:
                begin
                    if (s.phase >= 3'd3) return 1'b1;
                    s.phase = s.phase + 3'd1;
                end
                i2cm_pkg::CMD_WRITE:
                begin
                    if (s.phase == 3'd0 || s.phase == 3'd2) begin
                        s.phase = s.phase + 3'd1;
                    end
                    else if (s.phase == 3'd1) begin
                        s.scl = 1'b0;
                        if (s.bit_idx == i2cm_pkg::LAST_BIT) s.sda = 1'b1;
                        s.shreg   = {s.shreg[6:0], 1'b0};
                        s.bit_idx = s.bit_idx + 4'd1;
                        s.phase   = (s.bit_idx >= i2cm_pkg::BITS_PER_BYTE) ? 3'd2 : 3'd0;
                    end
                    else begin
                        s.scl = 1'b0;
                        s.ack = sda_in;
                        return 1'b1;
                    end
                end
                default:
                begin
                    if (s.phase == 3'd0) begin
                        s.shreg = {s.shreg[6:0], sda_in};
                        s.phase = 3'd1;
                    end
                    else if (s.phase == 3'd1) begin
                        s.bit_idx = s.bit_idx + 4'd1;
                        s.phase   = (s.bit_idx >= i2cm_pkg::BITS_PER_BYTE) ? 3'd2 : 3'd0;
                    end
                    else if (s.phase >= 3'd5) begin
                        s.rd_byte = s.shreg;
                        return 1'b1;
                    end
                    else begin
                        s.phase = s.phase + 3'd1;
                    end
                end
            endcase
            drive_lines(s);
            return 1'b0;
        endfunction

        function i2cm_pkg::out_t step_engine(inout bus_state_t s, input i2cm_pkg::in_t req);
            i2cm_pkg::out_t o;
            logic [15:0]    lim;
            bit             is_cmd;
            bit             done;
            bit             rej;
            lim    = (cfg_ticks == 16'd0) ? 16'd1 : cfg_ticks;
            is_cmd = (req.func >= i2cm_pkg::CMD_START) && (req.func <= i2cm_pkg::CMD_READ_NACK);
            done   = 1'b0;
            rej    = 1'b0;
            if (s.cmd != i2cm_pkg::CMD_NONE) begin
                rej     = is_cmd;
                s.ticks = s.ticks + 16'd1;
                if (s.ticks >= lim) begin
                    s.ticks = '0;
                    if (close_phase(s, req.sda_in)) begin
                        s.cmd     = i2cm_pkg::CMD_NONE;
                        s.phase   = '0;
                        s.bit_idx = '0;
                        done      = 1'b1;
                    end
                end
            end
            else if (is_cmd) begin
                s.cmd     = req.func;
                s.phase   = '0;
                s.bit_idx = '0;
                s.ticks   = '0;
                s.shreg   = (req.func == i2cm_pkg::CMD_WRITE) ? req.data_byte : 8'd0;
                drive_lines(s);
            end
            o.scl       = s.scl;
            o.sda_out   = s.sda;
            o.busy_res  = (s.cmd != i2cm_pkg::CMD_NONE);
            o.done_res  = done;
            o.read_data = s.rd_byte;
            o.ack_error = s.ack;
            o.rejected  = rej;
            return o;
        endfunction

        function void note_request(i2cm_pkg::in_t req);
            expected_q.push_back(step_engine(st, req));
        endfunction

        function bit busy();
            return st.cmd != i2cm_pkg::CMD_NONE;
        endfunction

        // True when a plain tick accepted next would complete the command.
        function bit finishes_next();
            bus_state_t     t;
            i2cm_pkg::in_t  idle;
            i2cm_pkg::out_t o;
            t    = st;
            idle = '0;
            o    = step_engine(t, idle);
            return o.done_res;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("mismatch at result %0d: %s", results_seen, msg);
            errors++;
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(i2cm_pkg::out_t got);
            i2cm_pkg::out_t want;
            if (expected_q.size() == 0) begin
                report("result with no request outstanding");
            end
            else begin
                want = expected_q.pop_front();
                compare_field("scl", 8'(got.scl), 8'(want.scl));
                compare_field("sda_out", 8'(got.sda_out), 8'(want.sda_out));
                compare_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
                compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
                compare_field("read_data", got.read_data, want.read_data);
                compare_field("ack_error", 8'(got.ack_error), 8'(want.ack_error));
                compare_field("rejected", 8'(got.rejected), 8'(want.rejected));
            end
            results_seen++;
        endtask
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    i2cm_pkg::in_t  in_data = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    i2cm_pkg::out_t out_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [15:0]    cfg_data = '0;

    tick_scoreboard sb;

    int tx_calm = 0;
    int rx_calm = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    logic hold_off_req = 1'b0;
    int quiet_cycles = 0;
    int ticks_sent = 0;

    i2c_master_bit_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long; now and then a calm stretch.
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 5) begin
            calm = $urandom_range(20, 200);
            return 0;
        end
        if (r < 750) return 0;
        if (r < 970) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic pick_sda(int mode);
        if (mode == SDA_RANDOM) return 1'($urandom);
        return (mode == SDA_HIGH);
    endfunction

    task automatic offer(i2cm_pkg::in_t item);
        int gap;
        gap = idle_len(tx_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        sb.note_request(item);
        ticks_sent++;
    endtask

    // Issue one command, then tick until the engine is idle again.
    task automatic run_command(logic [2:0] func, logic [7:0] data, int sda_mode,
                               int noise_pct, int poke_pct);
        i2cm_pkg::in_t item;
        item.func      = func;
        item.data_byte = data;
        item.sda_in    = pick_sda(sda_mode);
        offer(item);
        while (sb.busy()) begin
            item.func      = i2cm_pkg::CMD_NONE;
            item.data_byte = 8'($urandom);
            item.sda_in    = pick_sda(sda_mode);
            if ($urandom_range(0, 99) < noise_pct) item.func = 3'($urandom_range(1, 7));
            // offer a fresh command on the finishing tick, which must be refused
            if (sb.finishes_next() && $urandom_range(0, 99) < poke_pct)
                item.func = 3'($urandom_range(i2cm_pkg::CMD_START, i2cm_pkg::CMD_READ_NACK));
            offer(item);
        end
    endtask

    task automatic random_transaction();
        int         n;
        int         ack_level;
        logic [2:0] f;
        if ($urandom_range(0, 99) < 15) begin
            // stray command, possibly an unused code or a plain tick
            run_command(3'($urandom_range(0, 7)), 8'($urandom), SDA_RANDOM, 20, 30);
            return;
        end
        ack_level = ($urandom_range(0, 99) < 80) ? SDA_LOW : SDA_HIGH;
        run_command(i2cm_pkg::CMD_START, 8'($urandom), SDA_RANDOM, 5, 20);
        run_command(i2cm_pkg::CMD_WRITE, 8'($urandom), ack_level, 5, 20);
        n = $urandom_range(1, 3);
        repeat (n) begin
            f = 3'($urandom_range(i2cm_pkg::CMD_WRITE, i2cm_pkg::CMD_READ_NACK));
            run_command(f, 8'($urandom), (f == i2cm_pkg::CMD_WRITE) ? ack_level : SDA_RANDOM,
                        5, 20);
        end
        run_command(i2cm_pkg::CMD_STOP, 8'($urandom), SDA_RANDOM, 5, 20);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_phase_ticks(logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.cfg_ticks = value;
    endtask

    // Receiver: check each accepted result, then pick the next stall level.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_result(out_data);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else begin
                stall_left = idle_len(rx_calm);
                if (stall_left > 0) begin
                    stall_left--;
                    out_stall <= 1'b1;
                end
                else begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        logic [15:0] settings[4];
        int          goal;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of phase_ticks
        run_command(i2cm_pkg::CMD_START, 8'h00, SDA_RANDOM, 0, 0);
        run_command(i2cm_pkg::CMD_WRITE, 8'hA5, SDA_LOW, 0, 0);
        run_command(i2cm_pkg::CMD_READ_NACK, 8'h00, SDA_RANDOM, 0, 0);
        run_command(i2cm_pkg::CMD_STOP, 8'h00, SDA_RANDOM, 0, 0);
        settle();

        write_phase_ticks(16'd1);
        run_command(i2cm_pkg::CMD_START, 8'h00, SDA_RANDOM, 0, 0);
        run_command(i2cm_pkg::CMD_WRITE, 8'hFF, SDA_HIGH, 0, 0);
        run_command(i2cm_pkg::CMD_WRITE, 8'h00, SDA_LOW, 50, 0);
        run_command(i2cm_pkg::CMD_READ_ACK, 8'h00, SDA_HIGH, 0, 100);
        run_command(i2cm_pkg::CMD_READ_NACK, 8'hFF, SDA_LOW, 0, 100);
        run_command(FUNC_SPARE_A, 8'h5A, SDA_RANDOM, 0, 0);
        run_command(FUNC_SPARE_B, 8'hC3, SDA_RANDOM, 0, 0);
        run_command(i2cm_pkg::CMD_NONE, 8'h00, SDA_RANDOM, 0, 0);
        run_command(i2cm_pkg::CMD_STOP, 8'h00, SDA_RANDOM, 0, 0);
        settle();

        // zero is held as one tick per phase
        write_phase_ticks(16'd0);
        run_command(i2cm_pkg::CMD_START, 8'h00, SDA_RANDOM, 0, 0);
        run_command(i2cm_pkg::CMD_READ_ACK, 8'h00, SDA_RANDOM, 10, 50);
        run_command(i2cm_pkg::CMD_STOP, 8'h00, SDA_RANDOM, 0, 0);
        settle();

        // long phase: one start only, with the sender kept busy
        write_phase_ticks(16'd40);
        tx_calm = 250000;
        run_command(i2cm_pkg::CMD_START, 8'h00, SDA_RANDOM, 1, 50);
        tx_calm = 0;
        settle();

        settings[0] = 16'd1;
        settings[1] = 16'd2;
        settings[2] = 16'd3;
        settings[3] = 16'($urandom_range(1, 4));
        foreach (settings[i]) begin
            write_phase_ticks(settings[i]);
            // hold the receiver off once while the sender keeps offering ticks
            if (i == 0) hold_off_req <= 1'b1;
            goal = ticks_sent + PHASE_TICKS_GOAL;
            while (ticks_sent < goal) random_transaction();
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
